FILE: rtl/core/frc_pkg.sv
package frc_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned DenW = 31;

  typedef enum logic [1:0] {
    ORD_EQ = 2'd0,
    ORD_GT = 2'd1,
    ORD_LT = 2'd2
  } order_e;

  // lane result handed to the top-level multiply and compare
  typedef struct packed {
    logic        neg;
    logic [64:0] mag;
    logic [64:0] den;
  } frac_t;

endpackage

FILE: rtl/core/frc_divider.sv
// Restoring divider, one quotient bit per cycle.
module frc_divider #(
  parameter int unsigned W = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[W]) begin
        rem_d = {rem_q[W-2:0], quot_q[W-1]};
        quot_d = {quot_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

FILE: rtl/core/frc_lane.sv
// One fraction: gcd by repeated remainders, then two divisions, on one divider.
module frc_lane #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] num_i,
  input  logic [VALUE_WIDTH-1:0] den_i,
  output logic                   done_o,
  output frc_pkg::frac_t         frac_o
);
  import frc_pkg::*;

  localparam int unsigned W = VALUE_WIDTH + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVN = 5'b00100,
    S_DIVD = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  logic [W-1:0] n_q, d_q, a_q, b_q, qn_q;
  logic         neg_q;
  logic         div_start, div_done;
  logic [W-1:0] div_a, div_b, quot, rem;
  logic [W-1:0] n_abs, d_abs;
  logic         nn, dn;
  // divider busy flag tracked here so that a step starts only once
  logic         pend_q;
  logic         gcd_go;

  assign nn = num_i[VALUE_WIDTH-1];
  assign dn = den_i[VALUE_WIDTH-1];
  assign n_abs = nn ? W'(-{1'b1, num_i}) : {1'b0, num_i};
  assign d_abs = (den_i == '0) ? W'(1) : (dn ? W'(-{1'b1, den_i}) : {1'b0, den_i});

  // start a remainder step only when none is in flight
  assign gcd_go = (state_q == S_GCD) && (b_q != '0) && !pend_q && !div_done;

  frc_divider #(.W(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_a     = a_q;
    div_b     = b_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_GCD;
      S_GCD: begin
        // a % b until b is zero; a_q then holds the gcd
        if (b_q == '0) begin
          div_start = 1'b1;
          div_a = n_q;
          div_b = a_q;
          state_d = S_DIVN;
        end else begin
          div_start = gcd_go;
        end
      end
      S_DIVN: if (div_done) begin
        div_start = 1'b1;
        div_a = d_q;
        div_b = a_q;
        state_d = S_DIVD;
      end
      S_DIVD: if (div_done) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_GCD && b_q != '0) pend_q <= !div_done;
      else pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      n_q   <= n_abs;
      d_q   <= d_abs;
      a_q   <= n_abs;
      b_q   <= d_abs;
      neg_q <= (nn != (dn && den_i != '0));
    end else if (state_q == S_GCD && div_done) begin
      a_q <= b_q;
      b_q <= rem;
    end
    if (state_q == S_DIVN && div_done) qn_q <= quot;
  end

  assign done_o = (state_q == S_DONE);
  assign frac_o.neg = neg_q && (qn_q != '0);
  assign frac_o.mag = 65'(qn_q);
  assign frac_o.den = 65'(quot);
endmodule

FILE: rtl/core/fraction_reduce_and_compare.sv
// channel | dir | tdata bits (low first)
// s_axis  | in  | first_numerator, first_denominator, second_numerator, second_denominator
// m_axis  | out | first_reduced_num, first_reduced_den, second_reduced_num,
//                 second_reduced_den, order_code (128 bits used of 128)
// Timing: the gcd remainder loop dominates each item; each step runs on a lane's
// bit-serial divider, up to about 46 steps at 32 bits, then two divisions, the
// partial-product multiply and the compare.
// Reset: rst_ni clears control; no memories, no clearing pass.
// Stalls: one item at a time; s_axis_tready is low from accept until the result
// is taken.
module fraction_reduce_and_compare #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata, // fn, fd, sn, sd, 32 bits each
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata  // frn 32, frd 31, srn 32, srd 31, order 2
);
  import frc_pkg::*;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_RUN  = 5'b00010,
    T_MUL  = 5'b00100,
    T_CMP  = 5'b01000,
    T_OUT  = 5'b10000
  } top_e;

  top_e         st_q;
  logic         go;
  logic [1:0]   done_q;
  logic [1:0]   ldone;
  frac_t        fa, fb;
  frac_t        ra_q, rb_q;
  logic [127:0] p1_q, p2_q;
  logic [1:0]   mstep_q;
  logic [127:0] out_q;

  assign go = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == T_IDLE);

  frc_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_a (
    .clk_i, .rst_ni, .start_i(go),
    .num_i(VALUE_WIDTH'(s_axis_tdata[31:0])), .den_i(VALUE_WIDTH'(s_axis_tdata[63:32])),
    .done_o(ldone[0]), .frac_o(fa));
  frc_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_b (
    .clk_i, .rst_ni, .start_i(go),
    .num_i(VALUE_WIDTH'(s_axis_tdata[95:64])), .den_i(VALUE_WIDTH'(s_axis_tdata[127:96])),
    .done_o(ldone[1]), .frac_o(fb));

  // 32x32 partial products, one per cycle per cross product
  logic [31:0] a1, b1, a2, b2;
  logic [63:0] pp1, pp2;
  always_comb begin
    a1 = ra_q.mag[mstep_q[1]*32 +: 32];
    b1 = rb_q.den[mstep_q[0]*32 +: 32];
    a2 = rb_q.mag[mstep_q[1]*32 +: 32];
    b2 = ra_q.den[mstep_q[0]*32 +: 32];
    pp1 = a1 * b1;
    pp2 = a2 * b2;
  end

  function automatic logic [31:0] sat_num(frac_t f);
    if (f.neg) return (f.mag > 65'h80000000) ? 32'h80000000 : 32'(-f.mag);
    return (f.mag > 65'h7fffffff) ? 32'h7fffffff : f.mag[31:0];
  endfunction

  function automatic logic [30:0] sat_den(frac_t f);
    return (f.den > 65'h7fffffff) ? 31'h7fffffff : f.den[30:0];
  endfunction

  order_e ord;
  logic   sa_z, sb_z;
  always_comb begin
    sa_z = (ra_q.mag == '0);
    sb_z = (rb_q.mag == '0);
    if (sa_z && sb_z) ord = ORD_EQ;
    else if (ra_q.neg != rb_q.neg || sa_z || sb_z) begin
      // positive > zero > negative
      if (sa_z) ord = rb_q.neg ? ORD_GT : ORD_LT;
      else if (sb_z) ord = ra_q.neg ? ORD_LT : ORD_GT;
      else ord = ra_q.neg ? ORD_LT : ORD_GT;
    end else if (p1_q == p2_q) ord = ORD_EQ;
    else ord = ((p1_q > p2_q) != ra_q.neg) ? ORD_GT : ORD_LT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= T_IDLE;
      done_q  <= '0;
      mstep_q <= '0;
    end else begin
      case (st_q)
        T_IDLE: if (go) begin
          st_q <= T_RUN;
          done_q <= '0;
        end
        T_RUN: begin
          done_q <= done_q | ldone;
          if ((done_q | ldone) == 2'b11) begin
            st_q <= T_MUL;
            mstep_q <= '0;
          end
        end
        T_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd3) st_q <= T_CMP;
        end
        T_CMP: st_q <= T_OUT;
        T_OUT: if (m_axis_tready) st_q <= T_IDLE;
        default: st_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ldone[0]) ra_q <= fa;
    if (ldone[1]) rb_q <= fb;
    if (st_q == T_RUN) begin
      p1_q <= '0;
      p2_q <= '0;
    end else if (st_q == T_MUL) begin
      p1_q <= p1_q + (128'(pp1) << (32 * (mstep_q[1] + mstep_q[0])));
      p2_q <= p2_q + (128'(pp2) << (32 * (mstep_q[1] + mstep_q[0])));
    end
    if (st_q == T_CMP)
      out_q <= {ord, sat_den(rb_q), sat_num(rb_q), sat_den(ra_q), sat_num(ra_q)};
  end

  assign m_axis_tvalid = (st_q == T_OUT);
  assign m_axis_tdata  = out_q;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[62:32] != '0) else $error("zero denominator");
  a_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[127:126] != 2'b11) else $error("bad order code");
endmodule

FILE: tb/sv/tb_fraction_reduce_and_compare.sv
module tb_fraction_reduce_and_compare;
  import frc_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  // highest field first, so the first field lands in the lowest bits
  typedef struct packed {
    order_e      ord;
    logic [30:0] srd;
    logic [31:0] srn;
    logic [30:0] frd;
    logic [31:0] frn;
  } fraction_out_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
  } rat_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  fraction_out_t reduced_q[$];
  int            mismatches;
  int            idle_cycles;
  bit            src_gaps;
  bit            sink_stalls;

  fraction_reduce_and_compare u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic rat_t reduce_frac(logic [31:0] n, logic [31:0] d);
    rat_t        f;
    logic        nn, dn;
    logic [63:0] nm, dm, g;
    nn = n[31];
    dn = d[31];
    nm = {32'd0, nn ? -n : n};
    dm = {32'd0, dn ? -d : d};
    if (dm == 0) begin
      dm = 1;
      dn = 1'b0;
    end
    g = gcd64(nm, dm);
    f.mag = nm / g;
    f.den = dm / g;
    f.neg = (f.mag != 0) && (nn != dn);
    return f;
  endfunction

  function automatic logic [31:0] sat_num(rat_t f);
    logic [63:0] m;
    m = f.mag;
    if (f.neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return -m[31:0];
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic logic [30:0] sat_den(rat_t f);
    return (f.den > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : f.den[30:0];
  endfunction

  function automatic fraction_out_t predict_reduced(logic [127:0] data);
    fraction_out_t r;
    rat_t          a, b;
    int            sa, sb, c;
    logic [127:0]  p1, p2;
    a = reduce_frac(data[31:0], data[63:32]);
    b = reduce_frac(data[95:64], data[127:96]);
    sa = (a.mag == 0) ? 0 : (a.neg ? -1 : 1);
    sb = (b.mag == 0) ? 0 : (b.neg ? -1 : 1);
    if (sa != sb) c = (sa > sb) ? 1 : -1;
    else if (sa == 0) c = 0;
    else begin
      p1 = {64'd0, a.mag} * {64'd0, b.den};
      p2 = {64'd0, b.mag} * {64'd0, a.den};
      c = (p1 == p2) ? 0 : ((p1 > p2) ? 1 : -1);
      if (sa < 0) c = -c;
    end
    r.frn = sat_num(a);
    r.frd = sat_den(a);
    r.srn = sat_num(b);
    r.srd = sat_den(b);
    r.ord = (c == 0) ? ORD_EQ : ((c > 0) ? ORD_GT : ORD_LT);
    return r;
  endfunction

  // drive one transfer, with a random gap before it when src_gaps is set; tvalid stays high after it
  task automatic send_fractions(logic [31:0] fn, logic [31:0] fd,
                                logic [31:0] sn, logic [31:0] sd);
    int gap;
    gap = (src_gaps && $urandom_range(3) == 0) ? $urandom_range(14, 1) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sd, sn, fd, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    reduced_q.push_back(predict_reduced({sd, sn, fd, fn}));
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return -$urandom_range(20);
      2: return 32'h8000_0000 | $urandom_range(3);
      3: return 32'h7FFF_FFFF - $urandom_range(3);
      4: return $urandom_range(1000) * (1 << $urandom_range(20));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_fractions(0, 0, 0, 0);
    send_fractions(5, 0, -7, 0);
    send_fractions(0, -5, 3, 6);
    send_fractions(32'h7FFF_FFFF, 1, 32'h8000_0001, 1);
    send_fractions(32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_fractions(1, 32'h8000_0000, -1, 32'h8000_0000);
    send_fractions(32'h8000_0000, 32'h8000_0000, 1, 1);
    send_fractions(32'h8000_0000, -1, 1, 1);
    send_fractions(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    send_fractions(6, -4, -3, 2);
    send_fractions(2, 3, 3, 4);
    send_fractions(-2, 3, -3, 4);
    send_fractions(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFD);
    send_fractions(-12, 18, 2, -3);
    send_fractions(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random(int count);
    logic [31:0] fn, fd, sn, sd;
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      fn = rand_value();
      fd = rand_value();
      // make equal and near-equal values common
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(7, 1);
        sn = fn * k;
        sd = fd * k;
        if ($urandom_range(1)) sn = sn + 1;
      end else begin
        sn = rand_value();
        sd = rand_value();
      end
      send_fractions(fn, fd, sn, sd);
    end
  endtask

  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk_i);
    send_fractions(9, 3, 3, 1);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stalls && $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    fraction_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = fraction_out_t'(m_axis_tdata);
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = reduced_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h %0d got %h %h %h %h %0d",
                     want.frn, want.frd, want.srn, want.srd, want.ord,
                     got.frn, got.frd, got.srn, got.srd, got.ord);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatches    = 0;
    idle_cycles   = 0;
    src_gaps      = 1'b1;
    sink_stalls   = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(1100);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random(230);
    s_axis_tvalid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (1300) @(posedge clk_i);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: fraction_reduce_and_compare.f
rtl/core/frc_pkg.sv
rtl/core/frc_divider.sv
rtl/core/frc_lane.sv
rtl/core/fraction_reduce_and_compare.sv
tb/sv/tb_fraction_reduce_and_compare.sv
